[hdl/plfm_pkg.sv]
// Package for the price level FIFO matcher: event and kind codes, the
// sequencer state type, the shared ALU request/response and the result word.
// No dependencies.
`timescale 1ns / 1ps

package plfm_pkg;

   localparam int PLFM_DEPTH = 32;

   // A take stops after this many matches and reports what is left.
   localparam logic [5:0] MATCH_CAP = 6'd32;

   localparam logic [1:0] KIND_MAKE   = 2'd0;
   localparam logic [1:0] KIND_TAKE   = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;

   localparam logic [2:0] EV_MAKE_OK   = 3'd0;
   localparam logic [2:0] EV_MAKE_FULL = 3'd1;
   localparam logic [2:0] EV_MATCH     = 3'd2;
   localparam logic [2:0] EV_TAKE_DONE = 3'd3;
   localparam logic [2:0] EV_CANCEL    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAN_RD,
      ST_CAN_CHK,
      ST_TK_CHK,
      ST_TK_EXE
   } state_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_TAKE
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
      logic [37:0] acc;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] minv;
      logic [31:0] a_left;
      logic [31:0] b_left;
      logic [37:0] acc_out;
   } alu_rsp_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] maker_id;
      logic [31:0] taker_id;
      logic [31:0] fill_qty;
      logic [31:0] maker_left;
      logic [31:0] taker_left;
      logic        maker_done;
      logic        taker_done;
      logic        last;
   } rsp_word_type;

endpackage

[hdl/plfm_alu.sv]
// Shared arithmetic unit: minimum of two quantities, both remainders and a
// 38-bit running total add or subtract. Depends on plfm_pkg.
`timescale 1ns / 1ps

module plfm_alu
   import plfm_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   always_comb begin
      rsp.minv   = (req.a < req.b) ? req.a : req.b;
      rsp.a_left = req.a - rsp.minv;
      rsp.b_left = req.b - rsp.minv;
      unique case (req.op)
         ALU_ADD:  rsp.acc_out = req.acc + 38'(req.b);
         ALU_SUB:  rsp.acc_out = req.acc - 38'(req.b);
         ALU_TAKE: rsp.acc_out = req.acc - 38'(rsp.minv);
         default:  rsp.acc_out = req.acc;
      endcase
   end

endmodule

[hdl/plfm_ram.sv]
// Slot store for resting orders: id and quantity arrays with separate write
// enables and one registered read port. Depends on plfm_pkg.
`timescale 1ns / 1ps

module plfm_ram
   import plfm_pkg::*;
#(
   parameter int DEPTH = PLFM_DEPTH,
   localparam int PW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_id_en,
   input  logic          wr_qty_en,
   input  logic [PW-1:0] wr_addr,
   input  logic [31:0]   wr_id,
   input  logic [31:0]   wr_qty,
   input  logic          rd_en,
   input  logic [PW-1:0] rd_addr,
   output logic [31:0]   rd_id,
   output logic [31:0]   rd_qty
);

   logic [31:0] id_mem  [DEPTH];
   logic [31:0] qty_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_id_en) begin
         id_mem[wr_addr] <= wr_id;
      end
      if (wr_qty_en) begin
         qty_mem[wr_addr] <= wr_qty;
      end
   end

   // Read data holds between reads, so a stalled match keeps its operands.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id  <= id_mem[rd_addr];
         rd_qty <= qty_mem[rd_addr];
      end
   end

endmodule

[hdl/price_level_fifo_matcher_unit.sv]
// One price level of an order book. A make word appends a resting order, or is
// rejected when all DEPTH slots are occupied. A cancel word reads and checks
// each occupied slot in turn, marking every live entry with its id, then gives
// a cancel notice. A take word reads and then matches the front entry for each
// match and drops cancelled entries at the front without a result, then gives
// a closing result; at most 32 matches are given per take. Reads go through the
// single registered read port of the slot store, sums use the one shared ALU,
// and a step that gives a result waits while a held result sees rsp_ready low.
// Depends on plfm_pkg, plfm_alu and plfm_ram.
`timescale 1ns / 1ps

module price_level_fifo_matcher_unit
   import plfm_pkg::*;
#(
   parameter int DEPTH = PLFM_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_order_id,
   input  logic [31:0] req_qty,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [31:0] rsp_maker_id,
   output logic [31:0] rsp_taker_id,
   output logic [31:0] rsp_fill_qty,
   output logic [31:0] rsp_maker_left,
   output logic [31:0] rsp_taker_left,
   output logic        rsp_maker_done,
   output logic        rsp_taker_done,
   output logic [36:0] rsp_total_resting,
   output logic        rsp_is_empty,
   output logic        rsp_last
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   state_type    state_ff, state_in;
   logic [31:0]  id_ff, id_in;
   logic [31:0]  q_ff, q_in;
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [37:0]  total_ff, total_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [5:0]   nmatch_ff, nmatch_in;
   logic [PW-1:0] addr_ff, addr_in;
   logic [DEPTH-1:0] cancelled_ff, cancelled_in;

   rsp_word_type rsp_ff, rsp_word;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [36:0]  rsp_total_ff;
   logic         rsp_empty_ff;
   logic         emit;

   logic          out_free;
   logic          accept;
   logic          full;
   logic [PW-1:0] tail;
   logic [PW-1:0] scan_addr;
   logic [PW-1:0] head_next;

   logic          wr_id_en, wr_qty_en, rd_en;
   logic [PW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_id, wr_qty, rd_id, rd_qty;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[PW-1:0];
   endfunction

   plfm_ram #(.DEPTH(DEPTH)) u_ram (
      .clock     (clock),
      .wr_id_en  (wr_id_en),
      .wr_qty_en (wr_qty_en),
      .wr_addr   (wr_addr),
      .wr_id     (wr_id),
      .wr_qty    (wr_qty),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_id     (rd_id),
      .rd_qty    (rd_qty)
   );

   plfm_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (fill_ff == CW'(DEPTH));
   assign tail      = wrap_add(head_ff, fill_ff);
   assign scan_addr = wrap_add(head_ff, scan_ff);
   assign head_next = wrap_add(head_ff, CW'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_CANCEL) begin
                  state_in = ST_CAN_RD;
               end else if (req_kind == KIND_TAKE) begin
                  state_in = ST_TK_CHK;
               end
            end
         end
         ST_CAN_RD: begin
            if (scan_ff != fill_ff) begin
               state_in = ST_CAN_CHK;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CAN_CHK: state_in = ST_CAN_RD;
         ST_TK_CHK: begin
            if (q_ff == 32'd0 || fill_ff == '0 || nmatch_ff == MATCH_CAP) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (!cancelled_ff[head_ff]) begin
               state_in = ST_TK_EXE;
            end
         end
         ST_TK_EXE: begin
            if (out_free) begin
               state_in = ST_TK_CHK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and result words.
   always_comb begin
      id_in        = id_ff;
      q_in         = q_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      scan_in      = scan_ff;
      nmatch_in    = nmatch_ff;
      addr_in      = addr_ff;
      cancelled_in = cancelled_ff;
      wr_id_en     = 1'b0;
      wr_qty_en    = 1'b0;
      wr_addr      = tail;
      wr_id        = req_order_id;
      wr_qty       = req_qty;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      alu_req.op   = ALU_ADD;
      alu_req.a    = q_ff;
      alu_req.b    = rd_qty;
      alu_req.acc  = total_ff;
      emit         = 1'b0;
      rsp_word     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in     = req_order_id;
               q_in      = req_qty;
               scan_in   = '0;
               nmatch_in = '0;
               if (req_kind == KIND_MAKE) begin
                  emit               = 1'b1;
                  rsp_word.maker_id  = req_order_id;
                  rsp_word.last      = 1'b1;
                  alu_req.b          = req_qty;
                  if (full) begin
                     rsp_word.event_res = EV_MAKE_FULL;
                  end else begin
                     rsp_word.event_res = EV_MAKE_OK;
                     // A zero-quantity make is acknowledged but never stored.
                     if (req_qty != 32'd0) begin
                        wr_id_en           = 1'b1;
                        wr_qty_en          = 1'b1;
                        cancelled_in[tail] = 1'b0;
                        fill_in            = fill_ff + CW'(1);
                        total_in           = alu_rsp.acc_out;
                     end
                  end
               end
            end
         end
         ST_CAN_RD: begin
            if (scan_ff != fill_ff) begin
               rd_en   = 1'b1;
               rd_addr = scan_addr;
               addr_in = scan_addr;
            end else if (out_free) begin
               emit               = 1'b1;
               rsp_word.event_res = EV_CANCEL;
               rsp_word.maker_id  = id_ff;
               rsp_word.last      = 1'b1;
            end
         end
         ST_CAN_CHK: begin
            alu_req.op = ALU_SUB;
            scan_in    = scan_ff + CW'(1);
            if (!cancelled_ff[addr_ff] && rd_id == id_ff) begin
               cancelled_in[addr_ff] = 1'b1;
               total_in              = alu_rsp.acc_out;
            end
         end
         ST_TK_CHK: begin
            if (q_ff == 32'd0 || fill_ff == '0 || nmatch_ff == MATCH_CAP) begin
               if (out_free) begin
                  emit                = 1'b1;
                  rsp_word.event_res  = EV_TAKE_DONE;
                  rsp_word.taker_id   = id_ff;
                  rsp_word.taker_left = q_ff;
                  rsp_word.taker_done = (q_ff == 32'd0);
                  rsp_word.last       = 1'b1;
               end
            end else if (cancelled_ff[head_ff]) begin
               // A cancelled entry at the front is dropped without a result.
               cancelled_in[head_ff] = 1'b0;
               head_in               = head_next;
               fill_in               = fill_ff - CW'(1);
            end else begin
               rd_en = 1'b1;
            end
         end
         ST_TK_EXE: begin
            alu_req.op = ALU_TAKE;
            wr_addr    = head_ff;
            wr_qty     = alu_rsp.b_left;
            if (out_free) begin
               wr_qty_en           = 1'b1;
               q_in                = alu_rsp.a_left;
               total_in            = alu_rsp.acc_out;
               nmatch_in           = nmatch_ff + 6'd1;
               emit                = 1'b1;
               rsp_word.event_res  = EV_MATCH;
               rsp_word.maker_id   = rd_id;
               rsp_word.taker_id   = id_ff;
               rsp_word.fill_qty   = alu_rsp.minv;
               rsp_word.maker_left = alu_rsp.b_left;
               rsp_word.taker_left = alu_rsp.a_left;
               rsp_word.maker_done = (alu_rsp.b_left == 32'd0);
               rsp_word.taker_done = (alu_rsp.a_left == 32'd0);
               if (alu_rsp.b_left == 32'd0) begin
                  cancelled_in[head_ff] = 1'b0;
                  head_in               = head_next;
                  fill_in               = fill_ff - CW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         cancelled_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         cancelled_ff <= cancelled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      q_ff      <= q_in;
      scan_ff   <= scan_in;
      nmatch_ff <= nmatch_in;
      addr_ff   <= addr_in;
      if (emit) begin
         rsp_ff       <= rsp_word;
         rsp_total_ff <= total_in[36:0];
         rsp_empty_ff <= (total_in == 38'd0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_ff.event_res;
   assign rsp_maker_id      = rsp_ff.maker_id;
   assign rsp_taker_id      = rsp_ff.taker_id;
   assign rsp_fill_qty      = rsp_ff.fill_qty;
   assign rsp_maker_left    = rsp_ff.maker_left;
   assign rsp_taker_left    = rsp_ff.taker_left;
   assign rsp_maker_done    = rsp_ff.maker_done;
   assign rsp_taker_done    = rsp_ff.taker_done;
   assign rsp_total_resting = rsp_total_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_last          = rsp_ff.last;

endmodule
